/* rtl/core/bbr_pkg.sv */
package bbr_pkg;

    localparam int WORD_W  = 64;
    localparam int WIDX_W  = 10;
    localparam int BLKN_W  = 16;
    localparam int CNT_W   = 17;
    localparam int POP_W   = 7;
    localparam int BIT_W   = 6;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_MARK = 2'd1;
    localparam logic [1:0] OP_TEST = 2'd2;
    localparam logic [1:0] OP_MAP  = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef logic [CNT_W-1:0] cnt_t;

    // Adder tree, one level per pairing of the previous partial sums.
    function automatic logic [POP_W-1:0] popcount64(input logic [WORD_W-1:0] v);
        logic [1:0] s1 [32];
        logic [2:0] s2 [16];
        logic [3:0] s3 [8];
        logic [4:0] s4 [4];
        logic [5:0] s5 [2];
        for (int i = 0; i < 32; i++)
        begin
            s1[i] = {1'b0, v[2*i]} + {1'b0, v[2*i+1]};
        end
        for (int i = 0; i < 16; i++)
        begin
            s2[i] = {1'b0, s1[2*i]} + {1'b0, s1[2*i+1]};
        end
        for (int i = 0; i < 8; i++)
        begin
            s3[i] = {1'b0, s2[2*i]} + {1'b0, s2[2*i+1]};
        end
        for (int i = 0; i < 4; i++)
        begin
            s4[i] = {1'b0, s3[2*i]} + {1'b0, s3[2*i+1]};
        end
        for (int i = 0; i < 2; i++)
        begin
            s5[i] = {1'b0, s4[2*i]} + {1'b0, s4[2*i+1]};
        end
        return {1'b0, s5[0]} + {1'b0, s5[1]};
    endfunction

    // Sum of two counts, clamped to the largest count.
    function automatic cnt_t sat_add(input cnt_t a, input cnt_t b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? CNT_MAX : s[CNT_W-1:0];
    endfunction

endpackage

/* rtl/core/bbr_ifs.sv */
interface bbr_req_if import bbr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [1:0]        op;
    logic [BLKN_W-1:0] block_number;
    logic [WIDX_W-1:0] word_index;
    logic [WORD_W-1:0] word_data;

    modport source (output valid, output op, output block_number, output word_index,
                    output word_data, input ready);
    modport sink   (input valid, input op, input block_number, input word_index,
                    input word_data, output ready);
endinterface

interface bbr_rsp_if import bbr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             bit_set;
    logic [CNT_W-1:0] mapped_index;
    logic [CNT_W-1:0] running_total;

    modport source (output valid, output bit_set, output mapped_index,
                    output running_total, input ready);
    modport sink   (input valid, input bit_set, input mapped_index,
                    input running_total, output ready);
endinterface

/* rtl/core/bbr_ram.sv */
module bbr_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds its value until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sparse_block_bitmap_rank.sv */
// Channel  Direction  Payload
// req      in         op, block_number, word_index, word_data
// rsp      out        bit_set, mapped_index, running_total
//
// Load, mark, test and map of an absent bit pass through the DIV, BLK, EXEC and DONE states to the result register.
// Map of a present bit also passes through SCAN, which reads the words before it in its bitmap block;
// the single read port of the bitmap memory scans one word per cycle.
// After reset a clearing pass over min(NUM_BLOCKS*BLOCK_WORDS, 1024) words zeroes both
// memories; req.ready stays low until it ends. One transaction is worked on at a time;
// a new one is taken while the previous result still waits on rsp.
module sparse_block_bitmap_rank import bbr_pkg::*; #(
    parameter int NUM_BLOCKS  = 16,
    parameter int BLOCK_WORDS = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    bbr_req_if.sink   req,
    bbr_rsp_if.source rsp
);

    // Only words below 1024 can be addressed by the 10-bit word index.
    localparam int STORE_WORDS = NUM_BLOCKS * BLOCK_WORDS;
    localparam int MEM_WORDS   = (STORE_WORDS < 1024) ? STORE_WORDS : 1024;
    localparam int MAW         = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int NBR         = (MEM_WORDS + BLOCK_WORDS - 1) / BLOCK_WORDS;
    localparam int BAW         = (NBR > 1) ? $clog2(NBR) : 1;

    localparam logic [WIDX_W:0] MEM_LIM  = (WIDX_W + 1)'(MEM_WORDS);
    localparam logic [WIDX_W:0] NBR_LIM  = (WIDX_W + 1)'(NBR);
    localparam logic [MAW-1:0]  CLR_LAST = MAW'(MEM_WORDS - 1);

    // Block number of a word by reciprocal multiplication; exact for 10-bit words.
    localparam int          DIV_S   = 22;
    localparam int          DIV_M_I = ((1 << DIV_S) + BLOCK_WORDS - 1) / BLOCK_WORDS;
    localparam logic [22:0] DIV_M   = 23'(DIV_M_I);
    localparam logic [22:0] BW_C    = 23'(BLOCK_WORDS);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_BLK   = 3'd3;
    localparam logic [2:0] ST_EXEC  = 3'd4;
    localparam logic [2:0] ST_SCAN  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [MAW-1:0]    clr_reg, clr_next;
    cnt_t              load_total_reg, load_total_next;
    logic              pend_reg, pend_next;
    logic              out_valid_reg, out_valid_next;

    logic [1:0]        op_reg, op_next;
    logic [WIDX_W-1:0] wa_reg, wa_next;
    logic [BIT_W-1:0]  bitpos_reg, bitpos_next;
    logic [WORD_W-1:0] data_reg, data_next;
    logic              in_range_reg, in_range_next;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [31:0]       prod_reg, prod_next;
    logic [BAW-1:0]    blk_reg, blk_next;
    logic [WIDX_W-1:0] first_reg, first_next;
    logic [WIDX_W-1:0] k_reg, k_next;
    cnt_t              count_reg, count_next;
    logic              res_bit_reg, res_bit_next;
    cnt_t              res_map_reg, res_map_next;
    logic              out_bit_reg, out_bit_next;
    cnt_t              out_map_reg, out_map_next;
    cnt_t              out_total_reg, out_total_next;

    logic              bm_we, bm_re;
    logic [MAW-1:0]    bm_waddr, bm_raddr;
    logic [WORD_W-1:0] bm_wdata, bm_rdata;
    logic              bs_we, bs_re;
    logic [BAW-1:0]    bs_waddr, bs_raddr;
    cnt_t              bs_wdata, bs_rdata;

    logic              accept;
    logic              out_take;
    logic [WIDX_W-1:0] req_wa;
    logic [WIDX_W-1:0] quot;
    logic [22:0]       first_full;
    logic [WORD_W-1:0] low_mask;
    cnt_t              base_total;
    cnt_t              scan_cnt;

    bbr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MEM_WORDS)
    ) u_bitmap_ram (
        .clk   (clk),
        .we    (bm_we),
        .waddr (bm_waddr),
        .wdata (bm_wdata),
        .re    (bm_re),
        .raddr (bm_raddr),
        .rdata (bm_rdata)
    );

    bbr_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NBR)
    ) u_base_ram (
        .clk   (clk),
        .we    (bs_we),
        .waddr (bs_waddr),
        .wdata (bs_wdata),
        .re    (bs_re),
        .raddr (bs_raddr),
        .rdata (bs_rdata)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid & req.ready;
    assign out_take  = !out_valid_reg || rsp.ready;
    assign req_wa    = (req.op == OP_LOAD) ? req.word_index : req.block_number[BLKN_W-1:BIT_W];
    assign quot       = prod_reg[DIV_S+WIDX_W-1:DIV_S];
    assign first_full = 23'(quot) * BW_C;
    assign low_mask   = (64'd1 << bitpos_reg) - 64'd1;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        load_total_next = load_total_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        op_next         = op_reg;
        wa_next         = wa_reg;
        bitpos_next     = bitpos_reg;
        data_next       = data_reg;
        in_range_next   = in_range_reg;
        word_next       = word_reg;
        prod_next       = prod_reg;
        blk_next        = blk_reg;
        first_next      = first_reg;
        k_next          = k_reg;
        count_next      = count_reg;
        res_bit_next    = res_bit_reg;
        res_map_next    = res_map_reg;
        out_bit_next    = out_bit_reg;
        out_map_next    = out_map_reg;
        out_total_next  = out_total_reg;
        bm_we           = 1'b0;
        bm_waddr        = wa_reg[MAW-1:0];
        bm_wdata        = data_reg;
        bm_re           = 1'b0;
        bm_raddr        = wa_reg[MAW-1:0];
        bs_we           = 1'b0;
        bs_waddr        = blk_reg;
        bs_wdata        = '0;
        bs_re           = 1'b0;
        bs_raddr        = blk_reg;
        base_total      = '0;
        scan_cnt        = count_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                bm_we    = 1'b1;
                bm_waddr = clr_reg;
                bm_wdata = '0;
                bs_we    = ((WIDX_W + 1)'(clr_reg) < NBR_LIM);
                bs_waddr = clr_reg[BAW-1:0];
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next     = req.op;
                    wa_next     = req_wa;
                    bitpos_next = req.block_number[BIT_W-1:0];
                    data_next   = req.word_data;
                    bm_re       = 1'b1;
                    bm_raddr    = req_wa[MAW-1:0];
                    state_next  = ST_DIV;
                end
            end
            ST_DIV:
            begin
                word_next     = bm_rdata;
                prod_next     = 32'(wa_reg) * 32'(DIV_M);
                in_range_next = ({1'b0, wa_reg} < MEM_LIM);
                state_next    = ST_BLK;
            end
            ST_BLK:
            begin
                blk_next   = quot[BAW-1:0];
                first_next = first_full[WIDX_W-1:0];
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                res_bit_next = 1'b0;
                res_map_next = '0;
                state_next   = ST_DONE;
                unique case (op_reg)
                    OP_LOAD:
                    begin
                        if (in_range_reg)
                        begin
                            // Word zero restarts the running total.
                            base_total = (wa_reg == '0) ? '0 : load_total_reg;
                            if (first_reg == wa_reg)
                            begin
                                bs_we    = 1'b1;
                                bs_wdata = base_total;
                            end
                            bm_we           = 1'b1;
                            load_total_next = sat_add(base_total,
                                                      CNT_W'(popcount64(data_reg)));
                        end
                    end
                    OP_MARK:
                    begin
                        if (in_range_reg)
                        begin
                            bm_we    = 1'b1;
                            bm_wdata = word_reg | (64'd1 << bitpos_reg);
                        end
                    end
                    OP_TEST:
                    begin
                        res_bit_next = in_range_reg & word_reg[bitpos_reg];
                    end
                    OP_MAP:
                    begin
                        if (in_range_reg && word_reg[bitpos_reg])
                        begin
                            res_bit_next = 1'b1;
                            bs_re        = 1'b1;
                            count_next   = CNT_W'(popcount64(word_reg & low_mask)) + 1'b1;
                            k_next       = first_reg;
                            pend_next    = 1'b0;
                            state_next   = ST_SCAN;
                        end
                    end
                endcase
            end
            ST_SCAN:
            begin
                // Reads of the earlier words of the block are issued back to back;
                // each returns in the next cycle and is folded into the count.
                if (pend_reg)
                begin
                    scan_cnt = count_reg + CNT_W'(popcount64(bm_rdata));
                end
                count_next = scan_cnt;
                if (k_reg != wa_reg)
                begin
                    bm_re     = 1'b1;
                    bm_raddr  = k_reg[MAW-1:0];
                    k_next    = k_reg + 1'b1;
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        res_map_next = sat_add(count_reg, bs_rdata);
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_take)
                begin
                    out_valid_next = 1'b1;
                    out_bit_next   = res_bit_reg;
                    out_map_next   = res_map_reg;
                    out_total_next = load_total_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_reg        <= '0;
            load_total_reg <= '0;
            pend_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            load_total_reg <= load_total_next;
            pend_reg       <= pend_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        wa_reg        <= wa_next;
        bitpos_reg    <= bitpos_next;
        data_reg      <= data_next;
        in_range_reg  <= in_range_next;
        word_reg      <= word_next;
        prod_reg      <= prod_next;
        blk_reg       <= blk_next;
        first_reg     <= first_next;
        k_reg         <= k_next;
        count_reg     <= count_next;
        res_bit_reg   <= res_bit_next;
        res_map_reg   <= res_map_next;
        out_bit_reg   <= out_bit_next;
        out_map_reg   <= out_map_next;
        out_total_reg <= out_total_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.bit_set       = out_bit_reg;
    assign rsp.mapped_index  = out_map_reg;
    assign rsp.running_total = out_total_reg;

endmodule

/* sim/bitmap_rank_checker.sv */
`timescale 1ns / 1ps

module bitmap_rank_checker import bbr_pkg::*; #(
    parameter int NUM_BLOCKS  = 16,
    parameter int BLOCK_WORDS = 64
) (
    input  logic clk,
    input  logic rst_n,
    bbr_req_if   req,
    bbr_rsp_if   rsp,
    output int   fails,
    output int   outstanding
);

    localparam int STORE_WORDS = NUM_BLOCKS * BLOCK_WORDS;

    typedef struct packed {
        logic bit_set;
        cnt_t mapped_index;
        cnt_t running_total;
    } rank_result_t;

    logic [WORD_W-1:0] shadow_words [STORE_WORDS];
    cnt_t              shadow_base [NUM_BLOCKS];
    int unsigned       shadow_total;
    rank_result_t      due_results [$];
    rank_result_t      seen_result;
    rank_result_t      due_result;
    int                fail_count;
    int                result_count;

    assign fails       = fail_count;
    assign outstanding = due_results.size();

    function automatic int unsigned clamp_count(input int unsigned v);
        return (v > CNT_MAX) ? CNT_MAX : v;
    endfunction

    // Updates the shadow bitmap for one transaction and returns what the block must answer.
    function automatic rank_result_t apply_request(input logic [1:0] op,
                                                   input logic [BLKN_W-1:0] bn,
                                                   input logic [WIDX_W-1:0] wi,
                                                   input logic [WORD_W-1:0] wd);
        rank_result_t r;
        int unsigned  w;
        int unsigned  blk;
        int unsigned  cnt;
        r   = '0;
        w   = bn >> 6;
        blk = w / BLOCK_WORDS;
        case (op)
            OP_LOAD:
            begin
                if (wi < STORE_WORDS)
                begin
                    if (wi == 0)
                    begin
                        shadow_total = 0;
                    end
                    if (wi % BLOCK_WORDS == 0)
                    begin
                        shadow_base[wi / BLOCK_WORDS] = cnt_t'(shadow_total);
                    end
                    shadow_words[wi] = wd;
                    shadow_total = clamp_count(shadow_total + $countones(wd));
                end
            end
            OP_MARK:
            begin
                if (w < STORE_WORDS)
                begin
                    shadow_words[w][bn[5:0]] = 1'b1;
                end
            end
            OP_TEST:
            begin
                if (w < STORE_WORDS)
                begin
                    r.bit_set = shadow_words[w][bn[5:0]];
                end
            end
            default:
            begin
                if (w < STORE_WORDS && shadow_words[w][bn[5:0]])
                begin
                    // The base is whatever was recorded at load, even if marks came later.
                    cnt = shadow_base[blk] + 1;
                    for (int k = blk * BLOCK_WORDS; k < w; k++)
                    begin
                        cnt += $countones(shadow_words[k]);
                    end
                    cnt += $countones(shadow_words[w] & ((64'd1 << bn[5:0]) - 64'd1));
                    r.bit_set      = 1'b1;
                    r.mapped_index = cnt_t'(clamp_count(cnt));
                end
            end
        endcase
        r.running_total = cnt_t'(shadow_total);
        return r;
    endfunction

    task automatic note_failure(input string msg);
        fail_count++;
        if (fail_count <= 10)
        begin
            $display("%s", msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_WORDS; i++)
            begin
                shadow_words[i] = '0;
            end
            for (int i = 0; i < NUM_BLOCKS; i++)
            begin
                shadow_base[i] = '0;
            end
            shadow_total = 0;
            due_results.delete();
            fail_count   = 0;
            result_count = 0;
        end
        else
        begin
            if (req.valid && req.ready)
            begin
                due_results.push_back(apply_request(req.op, req.block_number,
                                                    req.word_index, req.word_data));
            end
            if (rsp.valid && rsp.ready)
            begin
                seen_result.bit_set       = rsp.bit_set;
                seen_result.mapped_index  = rsp.mapped_index;
                seen_result.running_total = rsp.running_total;
                if (due_results.size() == 0)
                begin
                    note_failure($sformatf(
                        "result %0d unexpected: bit_set=%0b mapped_index=%0d total=%0d",
                        result_count, seen_result.bit_set,
                        seen_result.mapped_index, seen_result.running_total));
                end
                else
                begin
                    due_result = due_results.pop_front();
                    if (seen_result.bit_set !== due_result.bit_set
                        || seen_result.mapped_index !== due_result.mapped_index
                        || seen_result.running_total !== due_result.running_total)
                    begin
                        note_failure($sformatf(
                            "result %0d: expected %0b/%0d/%0d, got %0b/%0d/%0d",
                            result_count, due_result.bit_set,
                            due_result.mapped_index, due_result.running_total,
                            seen_result.bit_set, seen_result.mapped_index,
                            seen_result.running_total));
                    end
                end
                result_count++;
            end
        end
    end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps

module tb import bbr_pkg::*; ();

    localparam int NUM_BLOCKS     = 16;
    localparam int BLOCK_WORDS    = 64;
    localparam int STORE_WORDS    = NUM_BLOCKS * BLOCK_WORDS;
    localparam int RANDOM_ITEMS   = 500;
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic req_burst = 1'b0;
    logic rsp_burst = 1'b0;
    int   fails;
    int   outstanding;
    int   idle_cycles = 0;
    int   load_cursor = 0;
    int   top_word = 0;

    bbr_req_if req ();
    bbr_rsp_if rsp ();

    always #1 clk = ~clk;

    sparse_block_bitmap_rank #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_WORDS (BLOCK_WORDS)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    bitmap_rank_checker #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .BLOCK_WORDS (BLOCK_WORDS)
    ) rank_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .fails       (fails),
        .outstanding (outstanding)
    );

    function automatic logic [WORD_W-1:0] rnd_word();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [WIDX_W-1:0] rnd_widx();
        return WIDX_W'($urandom_range(0, STORE_WORDS - 1));
    endfunction

    function automatic logic [BLKN_W-1:0] rnd_bn();
        return BLKN_W'($urandom_range(0, 65535));
    endfunction

    // Mixture of dense, empty and sparse words so that ranks land everywhere.
    function automatic logic [WORD_W-1:0] draw_pattern();
        case ($urandom_range(0, 4))
            0:       return '1;
            1:       return '0;
            2:       return rnd_word() & rnd_word();
            3:       return 64'd1 << $urandom_range(0, 63);
            default: return rnd_word();
        endcase
    endfunction

    // Mostly picks a bit inside the part of the store that has been loaded.
    function automatic logic [BLKN_W-1:0] draw_position();
        logic [BLKN_W-1:0] bn;
        if ($urandom_range(0, 9) < 6)
        begin
            bn = BLKN_W'(($urandom_range(0, top_word) << 6) | $urandom_range(0, 63));
        end
        else
        begin
            bn = rnd_bn();
        end
        return bn;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [BLKN_W-1:0] bn,
                                input logic [WIDX_W-1:0] wi, input logic [WORD_W-1:0] wd);
        int gap;
        gap = req_burst ? 0 : $urandom_range(0, 7);
        if (gap != 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.valid        <= 1'b1;
        req.op           <= op;
        req.block_number <= bn;
        req.word_index   <= wi;
        req.word_data    <= wd;
        do @(posedge clk); while (!(req.valid && req.ready));
        @(negedge clk);
    endtask

    task automatic load_word(input int wi, input logic [WORD_W-1:0] wd);
        send_request(OP_LOAD, rnd_bn(), WIDX_W'(wi), wd);
        if (wi > top_word)
        begin
            top_word = wi;
        end
    endtask

    // Result side: a random stall before each transaction, with burst stretches.
    initial
    begin
        int stall;
        int taken;
        taken = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (taken % 40 == 0)
            begin
                rsp_burst = ($urandom_range(0, 3) == 0);
            end
            stall = rsp_burst ? 0 : $urandom_range(0, 7);
            if (stall != 0)
            begin
                rsp.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp.ready <= 1'b1;
            do @(posedge clk); while (!(rsp.valid && rsp.ready));
            taken++;
        end
    end

    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int pick;
        int wi;
        req.valid        = 1'b0;
        req.op           = OP_LOAD;
        req.block_number = '0;
        req.word_index   = '0;
        req.word_data    = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty store, ranks across word and block boundaries, marks that
        // leave the recorded bases stale, and the longest map of all.
        send_request(OP_TEST, 16'd0, rnd_widx(), rnd_word());
        send_request(OP_MAP, 16'hFFFF, rnd_widx(), rnd_word());
        load_word(0, '1);
        load_word(1, 64'h8000_0000_0000_0001);
        load_word(2, 64'h0000_0000_0000_00F0);
        load_word(63, 64'hAAAA_AAAA_AAAA_AAAA);
        load_word(64, 64'h0000_0000_0000_0001);
        load_word(960, 64'h0);
        load_word(1023, 64'h8000_0000_0000_0000);
        send_request(OP_MARK, 16'hFFFF, rnd_widx(), rnd_word());
        send_request(OP_MARK, 16'd200, rnd_widx(), rnd_word());
        send_request(OP_MARK, 16'd61440, rnd_widx(), rnd_word());
        send_request(OP_TEST, 16'd0, rnd_widx(), rnd_word());
        send_request(OP_TEST, 16'hFFFF, rnd_widx(), rnd_word());
        send_request(OP_TEST, 16'd200, rnd_widx(), rnd_word());
        send_request(OP_TEST, 16'd65, rnd_widx(), rnd_word());
        send_request(OP_MAP, 16'd0, rnd_widx(), rnd_word());
        send_request(OP_MAP, 16'd63, rnd_widx(), rnd_word());
        send_request(OP_MAP, 16'd64, rnd_widx(), rnd_word());
        send_request(OP_MAP, 16'd127, rnd_widx(), rnd_word());
        send_request(OP_MAP, 16'd200, rnd_widx(), rnd_word());
        send_request(OP_MAP, 16'd4096, rnd_widx(), rnd_word());
        send_request(OP_MAP, 16'd61440, rnd_widx(), rnd_word());
        send_request(OP_MAP, 16'hFFFF, rnd_widx(), rnd_word());
        load_word(0, '0);
        send_request(OP_TEST, 16'd0, rnd_widx(), rnd_word());

        load_word(0, rnd_word());
        load_cursor = 1;

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 40 == 0)
            begin
                req_burst = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
            begin
                case ($urandom_range(0, 9))
                    0:       wi = rnd_widx();
                    1:       wi = 0;
                    2:       wi = ((load_cursor / BLOCK_WORDS) + 1) * BLOCK_WORDS;
                    default: wi = load_cursor;
                endcase
                wi = wi % STORE_WORDS;
                load_word(wi, draw_pattern());
                load_cursor = (wi + 1) % STORE_WORDS;
            end
            else if (pick < 45)
            begin
                send_request(OP_MARK, draw_position(), rnd_widx(), rnd_word());
            end
            else if (pick < 65)
            begin
                send_request(OP_TEST, draw_position(), rnd_widx(), rnd_word());
            end
            else
            begin
                send_request(OP_MAP, draw_position(), rnd_widx(), rnd_word());
            end
        end
        req.valid <= 1'b0;

        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (100) @(negedge clk);
        if (fails == 0 && outstanding == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
